// ===== sv/txs_pkg.sv =====
// Shared types and codes for the transaction status and contention core.
package txs_pkg;

	localparam int unsigned SLOT_W  = 4;
	localparam int unsigned PRIO_W  = 8;
	localparam int unsigned RETRY_W = 16;
	localparam int unsigned STAMP_W = 64;
	localparam int unsigned EXT_W   = 9;

	typedef enum logic [2:0] {
		K_BEGIN      = 3'd0,
		K_RESTART    = 3'd1,
		K_ABORT      = 3'd2,
		K_END_DECIDE = 3'd3,
		K_END_FINISH = 3'd4,
		K_CONTEND    = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_INACTIVE   = 3'd0,
		ST_ACTIVE     = 3'd1,
		ST_ABORTED    = 3'd2,
		ST_COMMITTING = 3'd3,
		ST_ABORTING   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		RC_OK       = 3'd0,
		RC_INVALID  = 3'd1,
		RC_BUSY     = 3'd2,
		RC_ALREADY  = 3'd3,
		RC_CANCELED = 3'd4,
		RC_VALFAIL  = 3'd5
	} rc_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [SLOT_W-1:0] slot_a;
		logic [SLOT_W-1:0] slot_b;
		logic              b_present;
		logic              validation_ok;
		logic [PRIO_W-1:0] prio_a;
		logic [PRIO_W-1:0] prio_b;
		logic [PRIO_W-1:0] current_prio;
	} req_t;

	typedef struct packed {
		logic [2:0]         result_code;
		logic               win;
		logic               may_wait;
		logic [2:0]         status_after;
		logic [RETRY_W-1:0] retry_count;
	} rsp_t;

	// One slot table entry; all-zero is the reset value
	typedef struct packed {
		logic [2:0]         status;
		logic               finishing;
		logic [RETRY_W-1:0] retries;
		logic [STAMP_W-1:0] stamp;
	} slot_t;

	localparam int unsigned SLOT_BITS = $bits(slot_t);

	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

// ===== sv/txs_req_if.sv =====
// Request channel: valid/ready handshake carrying one request item.
interface txs_req_if;
	logic          valid;
	logic          ready;
	txs_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/txs_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one result item.
interface txs_rsp_if;
	logic          valid;
	logic          ready;
	txs_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/txs_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module txs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr0,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr1,
	output logic [WIDTH-1:0]                              rdata0,
	output logic [WIDTH-1:0]                              rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= mem_q[raddr0];
			rdata1 <= mem_q[raddr1];
		end
	end

endmodule

// ===== sv/txs_ctrl.sv =====
// Controller: sequences one request through table read and execute.
module txs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  txs_pkg::sts_t sts,
	output txs_pkg::cmd_t cmd
);

	txs_pkg::state_t state_q;
	txs_pkg::state_t state_d;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= txs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			txs_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = txs_pkg::S_EXEC;
				end
			end
			txs_pkg::S_EXEC: begin
				if (sts.out_free) begin
					state_d = txs_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = txs_pkg::S_IDLE;
			end
		endcase
	end

	// Drive commands
	always_comb begin
		req_ready   = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			txs_pkg::S_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			txs_pkg::S_EXEC: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== sv/txs_dp.sv =====
// Datapath: slot table, timestamp counter, request decode and result register.
module txs_dp #(
	parameter int unsigned NUM_SLOTS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  txs_pkg::cmd_t cmd,
	output txs_pkg::sts_t sts,
	input  txs_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output txs_pkg::rsp_t rsp_data
);

	localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	txs_pkg::req_t                       req_q;
	logic [NUM_SLOTS-1:0]                valid_q;
	logic                                va_q;
	logic                                vb_q;
	logic [txs_pkg::STAMP_W-1:0]         stamp_q;
	logic                                rsp_valid_q;
	txs_pkg::rsp_t                       rsp_q;

	logic [txs_pkg::EXT_W-1:0]           rd_a_ext;
	logic [txs_pkg::EXT_W-1:0]           rd_b_ext;
	logic [IW-1:0]                       rd_a_idx;
	logic [IW-1:0]                       rd_b_idx;
	logic [txs_pkg::EXT_W-1:0]           a_ext;
	logic [txs_pkg::EXT_W-1:0]           b_ext;
	logic [IW-1:0]                       wr_idx;
	logic [txs_pkg::SLOT_BITS-1:0]       rdata_a;
	logic [txs_pkg::SLOT_BITS-1:0]       rdata_b;
	txs_pkg::slot_t                      ea;
	txs_pkg::slot_t                      eb;
	txs_pkg::slot_t                      na;
	logic                                a_ok;
	logic                                b_ok;
	logic                                we;
	logic                                stamp_inc;
	logic [txs_pkg::STAMP_W-1:0]         stamp_next;
	txs_pkg::rsp_t                       rsp_d;

	// Table addresses come straight from the request as it transfers
	assign rd_a_ext = txs_pkg::EXT_W'(req_data.slot_a);
	assign rd_b_ext = txs_pkg::EXT_W'(req_data.slot_b);
	assign rd_a_idx = rd_a_ext[IW-1:0];
	assign rd_b_idx = rd_b_ext[IW-1:0];

	assign a_ext  = txs_pkg::EXT_W'(req_q.slot_a);
	assign b_ext  = txs_pkg::EXT_W'(req_q.slot_b);
	assign wr_idx = a_ext[IW-1:0];
	assign a_ok   = a_ext < txs_pkg::EXT_W'(NUM_SLOTS);
	assign b_ok   = b_ext < txs_pkg::EXT_W'(NUM_SLOTS);

	txs_ram #(
		.WIDTH(txs_pkg::SLOT_BITS),
		.DEPTH(NUM_SLOTS)
	) u_slots (
		.clk    (clk),
		.we     (we),
		.waddr  (wr_idx),
		.wdata  (na),
		.re     (cmd.capture),
		.raddr0 (rd_a_idx),
		.raddr1 (rd_b_idx),
		.rdata0 (rdata_a),
		.rdata1 (rdata_b)
	);

	// Hold the request and the entry valid bits sampled with the read
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_data;
			va_q  <= valid_q[rd_a_idx];
			vb_q  <= valid_q[rd_b_idx];
		end
	end

	// Entries never written read as the reset value
	assign ea = va_q ? txs_pkg::slot_t'(rdata_a) : '0;
	assign eb = vb_q ? txs_pkg::slot_t'(rdata_b) : '0;

	assign stamp_next = stamp_q + txs_pkg::STAMP_W'(1);

	// Execute the request against slot a (and slot b for contend)
	always_comb begin
		na        = ea;
		we        = 1'b0;
		stamp_inc = 1'b0;
		rsp_d     = '0;
		rsp_d.result_code = txs_pkg::RC_INVALID;
		if (a_ok) begin
			unique case (req_q.kind)
				txs_pkg::K_BEGIN, txs_pkg::K_RESTART: begin
					if (ea.status != txs_pkg::ST_INACTIVE || ea.finishing) begin
						rsp_d.result_code = txs_pkg::RC_ALREADY;
					end else begin
						rsp_d.result_code = txs_pkg::RC_OK;
						stamp_inc = 1'b1;
						we        = 1'b1;
						na.stamp  = stamp_next;
						na.status = txs_pkg::ST_ACTIVE;
						if (req_q.kind == txs_pkg::K_BEGIN) begin
							na.retries = '0;
						end
					end
				end
				txs_pkg::K_ABORT: begin
					unique case (ea.status)
						txs_pkg::ST_ACTIVE: begin
							rsp_d.result_code = txs_pkg::RC_OK;
							na.status = txs_pkg::ST_ABORTED;
							we        = 1'b1;
						end
						txs_pkg::ST_ABORTED, txs_pkg::ST_ABORTING: begin
							rsp_d.result_code = txs_pkg::RC_OK;
						end
						txs_pkg::ST_COMMITTING: begin
							rsp_d.result_code = txs_pkg::RC_BUSY;
						end
						default: begin
							rsp_d.result_code = txs_pkg::RC_INVALID;
						end
					endcase
				end
				txs_pkg::K_END_DECIDE: begin
					priority if (ea.finishing) begin
						rsp_d.result_code = txs_pkg::RC_BUSY;
					end else if (ea.status == txs_pkg::ST_INACTIVE) begin
						rsp_d.result_code = txs_pkg::RC_INVALID;
					end else if (ea.status != txs_pkg::ST_ACTIVE &&
							ea.status != txs_pkg::ST_ABORTED) begin
						rsp_d.result_code = txs_pkg::RC_BUSY;
					end else begin
						we           = 1'b1;
						na.finishing = 1'b1;
						if (ea.status == txs_pkg::ST_ACTIVE && req_q.validation_ok) begin
							rsp_d.result_code = txs_pkg::RC_OK;
							na.status = txs_pkg::ST_COMMITTING;
						end else begin
							na.status = txs_pkg::ST_ABORTING;
							// Saturating retry count
							if (ea.retries != {txs_pkg::RETRY_W{1'b1}}) begin
								na.retries = ea.retries + txs_pkg::RETRY_W'(1);
							end
							rsp_d.result_code = (ea.status == txs_pkg::ST_ACTIVE) ?
								txs_pkg::RC_VALFAIL : txs_pkg::RC_CANCELED;
						end
					end
				end
				txs_pkg::K_END_FINISH: begin
					if (ea.finishing) begin
						rsp_d.result_code = txs_pkg::RC_OK;
						we           = 1'b1;
						na.status    = txs_pkg::ST_INACTIVE;
						na.finishing = 1'b0;
					end else begin
						rsp_d.result_code = txs_pkg::RC_INVALID;
					end
				end
				txs_pkg::K_CONTEND: begin
					if (!req_q.b_present) begin
						// Against a plain task
						rsp_d.result_code = txs_pkg::RC_OK;
						if (ea.status == txs_pkg::ST_COMMITTING ||
								(ea.status == txs_pkg::ST_ACTIVE &&
								req_q.prio_a < req_q.current_prio)) begin
							rsp_d.win      = 1'b1;
							rsp_d.may_wait = 1'b1;
						end
					end else if (b_ok) begin
						// Against another transaction, status first
						rsp_d.result_code = txs_pkg::RC_OK;
						priority if (ea.status == txs_pkg::ST_ABORTED ||
								ea.status == txs_pkg::ST_ABORTING) begin
							rsp_d.win = 1'b0;
						end else if (eb.status == txs_pkg::ST_ABORTED ||
								eb.status == txs_pkg::ST_ABORTING) begin
							rsp_d.win = 1'b1;
						end else if (ea.status == txs_pkg::ST_COMMITTING) begin
							rsp_d.win = 1'b1;
						end else if (eb.status == txs_pkg::ST_COMMITTING) begin
							rsp_d.win = 1'b0;
						end else begin
							rsp_d.may_wait = (ea.status == txs_pkg::ST_ACTIVE) &&
								(eb.status == txs_pkg::ST_ACTIVE);
							priority if (req_q.prio_a < req_q.prio_b) begin
								rsp_d.win = 1'b1;
							end else if (req_q.prio_a > req_q.prio_b) begin
								rsp_d.win = 1'b0;
							end else begin
								rsp_d.win = ea.stamp < eb.stamp;
							end
						end
					end
				end
				default: begin
					rsp_d.result_code = txs_pkg::RC_INVALID;
				end
			endcase
			rsp_d.status_after = na.status;
			rsp_d.retry_count  = na.retries;
		end
		// Nothing is written unless the result can be stored
		if (!cmd.commit) begin
			we        = 1'b0;
			stamp_inc = 1'b0;
		end
	end

	// Entry valid bits and global timestamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			stamp_q <= '0;
		end else begin
			if (we) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (stamp_inc) begin
				stamp_q <= stamp_next;
			end
		end
	end

	// Result register: load on commit, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign sts.out_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid    = rsp_valid_q;
	assign rsp_data     = rsp_q;

endmodule

// ===== sv/transaction_status_and_contention_core.sv =====
// Transaction status and contention core: top level.
//
// Requests arrive on req (valid/ready); each yields exactly one result on rsp.
// A request is one of begin, restart, abort, end-decide, end-finish or contend
// against a slot table of NUM_SLOTS entries and a 64-bit global timestamp.
// At the transfer edge the slot table read is issued (registered read of the
// slot RAM) and the request is captured; the execute step then runs it, writes
// the slot back and loads the result register, once that register is free.
// req_ready is high only in the idle state, so a new request is not taken until
// the current one has executed. rsp.valid rises when the execute step loads the
// result register, and the result then waits there until it transfers on rsp.
// A result waiting in the output register does not block the next transfer on
// req; when rsp is stalled, the execute step holds until the register frees,
// so a second item waits there and req_ready stays low.
// Reset clears the slot valid bits, making every slot read as inactive with
// zero flags, timestamp and retry count, and clears the global timestamp; no
// clearing pass is needed, and requests are taken right after reset.
module transaction_status_and_contention_core #(
	parameter int unsigned NUM_SLOTS = 16
) (
	input logic         clk,
	input logic         arst_n,
	txs_req_if.sink     req,
	txs_rsp_if.source   rsp
);

	txs_pkg::cmd_t cmd;
	txs_pkg::sts_t sts;

	txs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	txs_dp #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req_data  (req.data),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_data  (rsp.data)
	);

endmodule
